FILE: design/bpfs_pkg.sv
// ----------------------------------------------------------------------------
// bpfs_pkg
// Shared types and constants of the bit-packed field store: store geometry,
// command codes, request and response payloads, controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfs_pkg;

   localparam int STORE_BITS  = 4096;
   localparam int WORD_W      = 64;
   localparam int OFF_W       = 6;
   localparam int STORE_WORDS = (STORE_BITS + WORD_W - 1) / WORD_W;
   localparam int WORD_AW     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

   localparam int CMD_W = 3;
   localparam int IDX_W = 12;
   localparam int WID_W = 7;
   localparam int POS_W = 6;

   localparam int PROD_W  = IDX_W + WID_W;
   localparam int START_W = (PROD_W > WORD_AW + OFF_W) ? PROD_W : WORD_AW + OFF_W;
   localparam int END_W   = START_W + 1;

   localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(8);
   localparam logic [WID_W-1:0] WIDTH_MAX   = WID_W'(WORD_W);

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 3'd0,
      CMD_WRITE = 3'd1,
      CMD_TEST  = 3'd2,
      CMD_SET   = 3'd3,
      CMD_CLEAR = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [IDX_W-1:0]  field_index;
      logic [WID_W-1:0]  width_override;
      logic [WORD_W-1:0] write_value;
      logic [POS_W-1:0]  bit_position;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_value;
      logic              bit_value;
      logic              out_of_range;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic rd;
      logic extract;
      logic merge;
      logic wr_lo;
      logic wr_hi;
   } dp_ctrl_type;

   typedef struct packed {
      logic oor;
      logic straddle;
      logic do_write;
   } dp_stat_type;

endpackage

`default_nettype wire

FILE: design/bit_packed_field_store.sv
// ----------------------------------------------------------------------------
// bit_packed_field_store
// Store of densely packed 1..64-bit fields with read, masked write, bit test,
// bit set and bit clear requests.
//
//   channel   ports                        direction  handshake
//   request   start, busy, req_data        in         start & !busy
//   response  rsp_valid, rsp_data          out        one-cycle strobe
//   config    csr_we, csr_wdata            in         csr_we
//
// A request steps through calc, read and response when out of range; read,
// test, and set/clear on a bit past the width add extract and merge; a write
// adds a low-word write-back, and a high-word one when it straddles two words.
// The response is never held off, and busy drops the cycle after it. The word
// memory has one write port, so a straddling field is written back one word
// per cycle. Reset clears the width register to 8 and the per-word valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_packed_field_store (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  bpfs_pkg::req_type  req_data,
   output logic               rsp_valid,
   output bpfs_pkg::rsp_type  rsp_data,
   input  wire                csr_we,
   input  wire [6:0]          csr_wdata
);
   import bpfs_pkg::*;

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   bpfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   bpfs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: design/bpfs_ctrl.sv
// ----------------------------------------------------------------------------
// bpfs_ctrl
// Sequencer of the field store: steps one request through address calc,
// word reads, extract, merge, word write-backs and the response cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfs_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   output logic                  rsp_valid,
   output bpfs_pkg::dp_ctrl_type ctrl,
   input  bpfs_pkg::dp_stat_type stat
);
   import bpfs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_READ,
      S_EXTRACT,
      S_MERGE,
      S_WR_LO,
      S_WR_HI,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (start) state_in = S_CALC;
         S_CALC:    state_in = S_READ;
         S_READ:    state_in = stat.oor ? S_RESP : S_EXTRACT;
         S_EXTRACT: state_in = S_MERGE;
         S_MERGE:   state_in = stat.do_write ? S_WR_LO : S_RESP;
         S_WR_LO:   state_in = stat.straddle ? S_WR_HI : S_RESP;
         S_WR_HI:   state_in = S_RESP;
         S_RESP:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   assign ctrl.load    = (state_ff == S_IDLE) && start;
   assign ctrl.calc    = (state_ff == S_CALC);
   assign ctrl.rd      = (state_ff == S_READ);
   assign ctrl.extract = (state_ff == S_EXTRACT);
   assign ctrl.merge   = (state_ff == S_MERGE);
   assign ctrl.wr_lo   = (state_ff == S_WR_LO);
   assign ctrl.wr_hi   = (state_ff == S_WR_HI);

endmodule

`default_nettype wire

FILE: design/bpfs_dp.sv
// ----------------------------------------------------------------------------
// bpfs_dp
// Datapath of the field store: width register, request latch, start-bit
// multiply, 64-bit word memory with per-word valid bits, field extract and
// word merge.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfs_dp (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_we,
   input  wire [6:0]             csr_wdata,
   input  bpfs_pkg::req_type     req_data,
   input  bpfs_pkg::dp_ctrl_type ctrl,
   output bpfs_pkg::dp_stat_type stat,
   output bpfs_pkg::rsp_type     rsp_data
);
   import bpfs_pkg::*;

   logic [WORD_W-1:0]      mem [STORE_WORDS];
   logic [STORE_WORDS-1:0] valid_ff;

   logic [WID_W-1:0]      cfg_width_ff;
   req_type               req_ff;
   logic [WID_W-1:0]      w_ff;
   logic [START_W-1:0]    start_ff;
   logic                  oor_ff;
   logic                  straddle_ff;
   logic [WORD_W-1:0]     lo_q_ff, hi_q_ff;
   logic                  lo_v_ff, hi_v_ff;
   logic [WORD_W-1:0]     cur_ff;
   logic                  bitv_ff;
   logic [2*WORD_W-1:0]   newpair_ff;

   logic [WID_W-1:0]      w_sel, w_in;
   logic [PROD_W-1:0]     prod;
   logic [END_W-1:0]      end_bit;
   logic                  oor;
   logic [OFF_W-1:0]      off;
   logic                  straddle;
   logic [WORD_AW-1:0]    lo_addr, hi_addr, wr_addr;
   logic [WORD_W-1:0]     wr_data;
   logic                  wr_en;
   logic [WORD_W-1:0]     mask;
   logic [2*WORD_W-1:0]   pair, pair_shr, mask_shl, val_shl;
   logic [WORD_W-1:0]     cur, onehot, new_val;
   logic                  pos_ok, do_write;

   // effective width: override, else register; zero becomes 1, above 64 saturates
   always_comb begin
      w_sel = (req_data.width_override != '0) ? req_data.width_override : cfg_width_ff;
      if (w_sel == '0) begin
         w_in = WID_W'(1);
      end else if (w_sel > WIDTH_MAX) begin
         w_in = WIDTH_MAX;
      end else begin
         w_in = w_sel;
      end
   end

   assign prod     = PROD_W'(req_ff.field_index) * PROD_W'(w_ff);
   assign end_bit  = END_W'(start_ff) + END_W'(w_ff);
   assign oor      = end_bit > END_W'(STORE_BITS);
   assign off      = start_ff[OFF_W-1:0];
   assign straddle = (8'(off) + 8'(w_ff)) > 8'(WORD_W);
   assign lo_addr  = start_ff[WORD_AW+OFF_W-1:OFF_W];
   assign hi_addr  = lo_addr + WORD_AW'(1);

   assign mask     = (w_ff == WIDTH_MAX) ? '1 : ((WORD_W'(1) << w_ff[OFF_W-1:0]) - WORD_W'(1));
   assign pair     = {(straddle_ff && hi_v_ff) ? hi_q_ff : '0, lo_v_ff ? lo_q_ff : '0};
   assign pair_shr = pair >> off;
   assign cur      = pair_shr[WORD_W-1:0] & mask;

   assign pos_ok   = {1'b0, req_ff.bit_position} < w_ff;
   assign onehot   = WORD_W'(1) << req_ff.bit_position;

   always_comb begin
      case (req_ff.cmd)
         CMD_WRITE: begin
            new_val  = req_ff.write_value & mask;
            do_write = 1'b1;
         end
         CMD_SET: begin
            new_val  = cur_ff | onehot;
            do_write = pos_ok;
         end
         CMD_CLEAR: begin
            new_val  = cur_ff & ~onehot;
            do_write = pos_ok;
         end
         default: begin
            new_val  = cur_ff;
            do_write = 1'b0;
         end
      endcase
   end

   assign mask_shl = {{WORD_W{1'b0}}, mask} << off;
   assign val_shl  = {{WORD_W{1'b0}}, new_val & mask} << off;

   assign wr_en   = ctrl.wr_lo || ctrl.wr_hi;
   assign wr_addr = ctrl.wr_hi ? hi_addr : lo_addr;
   assign wr_data = ctrl.wr_hi ? newpair_ff[2*WORD_W-1:WORD_W] : newpair_ff[WORD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff <= WIDTH_RESET;
         valid_ff     <= '0;
      end else begin
         if (csr_we) begin
            cfg_width_ff <= csr_wdata;
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd) begin
         lo_q_ff <= mem[lo_addr];
         hi_q_ff <= mem[hi_addr];
         lo_v_ff <= valid_ff[lo_addr];
         hi_v_ff <= valid_ff[hi_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff <= req_data;
         w_ff   <= w_in;
      end
      if (ctrl.calc) begin
         start_ff <= START_W'(prod);
      end
      if (ctrl.rd) begin
         oor_ff      <= oor;
         straddle_ff <= straddle;
      end
      if (ctrl.extract) begin
         cur_ff <= cur;
      end
      if (ctrl.merge) begin
         bitv_ff    <= (req_ff.cmd == CMD_TEST) && pos_ok && cur_ff[req_ff.bit_position];
         newpair_ff <= (pair & ~mask_shl) | val_shl;
      end
   end

   assign stat.oor      = oor;
   assign stat.straddle = straddle_ff;
   assign stat.do_write = do_write;

   assign rsp_data.read_value   = oor_ff ? '0 : cur_ff;
   assign rsp_data.bit_value    = ~oor_ff & bitv_ff;
   assign rsp_data.out_of_range = oor_ff;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for bit_packed_field_store. A directed table covers the store
// edges, every command, saturated and degenerate widths and bit positions
// past the width. Randomized requests follow under several default widths.
// A shadow copy of the bit store predicts each response, save where a table
// row gives its own, and a scoreboard checks every response strobe in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bpfs_pkg::*;

   localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int N_PHASES = 10;
   localparam int PHASE_REQUESTS = 75;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [IDX_W-1:0]  idx;
      logic [WID_W-1:0]  ovr;
      logic [WORD_W-1:0] wval;
      logic [POS_W-1:0]  pos;
      bit                chk;
      logic [WORD_W-1:0] rd;
      bit                bv;
      bit                oor;
   } stim_row_type;

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     start     = 1'b0;
   logic     busy;
   req_type  req_data  = '0;
   logic     rsp_valid;
   rsp_type  rsp_data;
   logic     csr_we    = 1'b0;
   logic [6:0] csr_wdata = '0;

   logic [WID_W-1:0]      width_shadow;
   logic [STORE_BITS-1:0] field_bits_shadow;
   rsp_type               pending_responses [$];
   int                    mismatches = 0;
   stim_row_type          stim_table [0:21];

   bit_packed_field_store u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned effective_width(logic [WID_W-1:0] ovr);
      int unsigned w;
      w = (ovr != '0) ? ovr : width_shadow;
      if (w == 0) w = 1;
      if (w > WORD_W) w = WORD_W;
      return w;
   endfunction

   function automatic rsp_type predict_field_access(req_type rq);
      rsp_type               r;
      int unsigned           w;
      int unsigned           base;
      logic [WORD_W-1:0]     m;
      logic [WORD_W-1:0]     cur;
      logic [WORD_W-1:0]     nxt;
      logic [STORE_BITS-1:0] wide_m;
      logic [STORE_BITS-1:0] wide_v;
      r = '0;
      w = effective_width(rq.width_override);
      base = rq.field_index * w;
      if (base + w > STORE_BITS) begin
         r.out_of_range = 1'b1;
         return r;
      end
      m = (w == WORD_W) ? '1 : ((64'd1 << w) - 64'd1);
      cur = WORD_W'(field_bits_shadow >> base) & m;
      nxt = cur;
      case (rq.cmd)
         CMD_WRITE: nxt = rq.write_value & m;
         CMD_TEST: begin
            if (rq.bit_position < w) r.bit_value = cur[rq.bit_position];
         end
         CMD_SET: begin
            if (rq.bit_position < w) nxt = cur | (64'd1 << rq.bit_position);
         end
         CMD_CLEAR: begin
            if (rq.bit_position < w) nxt = cur & ~(64'd1 << rq.bit_position);
         end
         default: ;
      endcase
      wide_m = '0;
      wide_m[WORD_W-1:0] = m;
      wide_v = '0;
      wide_v[WORD_W-1:0] = nxt;
      field_bits_shadow = (field_bits_shadow & ~(wide_m << base)) | (wide_v << base);
      r.read_value = cur;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type     rq;
      int unsigned w;
      int unsigned last;
      int unsigned lo;
      int unsigned hi;
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 4)       rq.cmd = CMD_READ;
      else if (sel < 9)  rq.cmd = CMD_WRITE;
      else if (sel < 12) rq.cmd = CMD_TEST;
      else if (sel < 15) rq.cmd = CMD_SET;
      else if (sel < 18) rq.cmd = CMD_CLEAR;
      else               rq.cmd = CMD_W'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
      sel = $urandom_range(0, 9);
      if (sel < 3)       rq.width_override = '0;
      else if (sel < 9)  rq.width_override = WID_W'($urandom_range(1, WORD_W));
      else               rq.width_override = WID_W'($urandom_range(WORD_W + 1, 127));
      w = effective_width(rq.width_override);
      last = STORE_BITS / w - 1;
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
         rq.field_index = IDX_W'($urandom_range(0, (last < 24) ? last : 24));
      end else if (sel < 8) begin
         rq.field_index = IDX_W'($urandom_range(0, last));
      end else if (sel < 9) begin
         lo = (last > 0) ? last - 1 : 0;
         hi = (last + 1 > 4095) ? 4095 : last + 1;
         rq.field_index = IDX_W'($urandom_range(lo, hi));
      end else begin
         rq.field_index = IDX_W'($urandom_range(0, 4095));
      end
      if ($urandom_range(0, 9) < 7) rq.bit_position = POS_W'($urandom_range(0, w - 1));
      else                          rq.bit_position = POS_W'($urandom_range(0, 63));
      sel = $urandom_range(0, 7);
      if (sel == 0)      rq.write_value = '1;
      else if (sel == 1) rq.write_value = '0;
      else               rq.write_value = {$urandom, $urandom};
      return rq;
   endfunction

   // Leaves start high at the falling edge after acceptance; callers drop it.
   task automatic send_request(input req_type rq, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      req_data = rq;
      start = 1'b1;
      do @(posedge clock); while (busy);
      predicted = predict_field_access(rq);
      pending_responses.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic idle_burst();
      start = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clock);
   endtask

   task automatic drain();
      start = 1'b0;
      do @(posedge clock); while (busy || pending_responses.size() != 0);
      @(negedge clock);
   endtask

   task automatic write_width(input logic [6:0] value);
      csr_wdata = value;
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
      width_shadow = value;
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type oldest;
      if (!reset && rsp_valid) begin
         if (pending_responses.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            oldest = pending_responses.pop_front();
            if (rsp_data.read_value !== oldest.read_value) begin
               $error("read_value: expected %h, got %h", oldest.read_value,
                      rsp_data.read_value);
               mismatches++;
            end
            if (rsp_data.bit_value !== oldest.bit_value) begin
               $error("bit_value: expected %b, got %b", oldest.bit_value,
                      rsp_data.bit_value);
               mismatches++;
            end
            if (rsp_data.out_of_range !== oldest.out_of_range) begin
               $error("out_of_range: expected %b, got %b", oldest.out_of_range,
                      rsp_data.out_of_range);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      req_type     rq;
      rsp_type     want;
      logic [6:0]  phase_width [N_PHASES];
      bit          idle_on;
      bit          quiet;
      width_shadow = WIDTH_RESET;
      field_bits_shadow = '0;
      stim_table = '{
         '{CMD_READ,   12'd0,    7'd0,   64'h0,                 6'd0,  1, 64'h0,  0, 0},
         '{CMD_READ,   12'd4095, 7'd0,   64'h0,                 6'd0,  1, 64'h0,  0, 1},
         '{CMD_WRITE,  12'd511,  7'd0,   '1,                    6'd0,  1, 64'h0,  0, 0},
         '{CMD_READ,   12'd511,  7'd0,   64'h0,                 6'd0,  1, 64'hff, 0, 0},
         '{CMD_WRITE,  12'd0,    7'd64,  64'hdeadbeef_01234567, 6'd0,  1, 64'h0,  0, 0},
         '{CMD_READ,   12'd0,    7'd64,  64'h0,                 6'd0,  1,
           64'hdeadbeef_01234567, 0, 0},
         '{CMD_WRITE,  12'd63,   7'd64,  '1,                    6'd63, 0, 64'h0,  0, 0},
         '{CMD_READ,   12'd64,   7'd64,  64'h0,                 6'd0,  1, 64'h0,  0, 1},
         '{CMD_READ,   12'd1,    7'd127, 64'h0,                 6'd0,  0, 64'h0,  0, 0},
         '{CMD_WRITE,  12'd1,    7'd37,  64'h01234567_89abcdef, 6'd0,  0, 64'h0,  0, 0},
         '{CMD_READ,   12'd1,    7'd37,  64'h0,                 6'd0,  0, 64'h0,  0, 0},
         '{CMD_TEST,   12'd1,    7'd37,  64'h0,                 6'd36, 0, 64'h0,  0, 0},
         '{CMD_TEST,   12'd1,    7'd37,  64'h0,                 6'd37, 0, 64'h0,  0, 0},
         '{CMD_SET,    12'd2,    7'd1,   64'h0,                 6'd0,  0, 64'h0,  0, 0},
         '{CMD_SET,    12'd5,    7'd7,   64'h0,                 6'd63, 0, 64'h0,  0, 0},
         '{CMD_CLEAR,  12'd1,    7'd37,  64'h0,                 6'd0,  0, 64'h0,  0, 0},
         '{CMD_CLEAR,  12'd0,    7'd64,  64'h0,                 6'd63, 0, 64'h0,  0, 0},
         '{CMD_RSVD_7, 12'd0,    7'd64,  '1,                    6'd5,  0, 64'h0,  0, 0},
         '{CMD_RSVD_5, 12'd1,    7'd37,  '1,                    6'd1,  0, 64'h0,  0, 0},
         '{CMD_RSVD_6, 12'd63,   7'd64,  64'h0,                 6'd2,  0, 64'h0,  0, 0},
         '{CMD_TEST,   12'd4095, 7'd1,   64'h0,                 6'd0,  0, 64'h0,  0, 0},
         '{CMD_WRITE,  12'd4095, 7'd2,   '1,                    6'd0,  1, 64'h0,  0, 1}
      };
      phase_width = '{7'd8, 7'd0, 7'd127, 7'd1, 7'd64, 7'd5, 7'd13, 7'd37,
                      7'($urandom_range(1, 64)), 7'($urandom_range(0, 127))};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_table[i]) begin
         rq.cmd            = stim_table[i].cmd;
         rq.field_index    = stim_table[i].idx;
         rq.width_override = stim_table[i].ovr;
         rq.write_value    = stim_table[i].wval;
         rq.bit_position   = stim_table[i].pos;
         want.read_value   = stim_table[i].rd;
         want.bit_value    = stim_table[i].bv;
         want.out_of_range = stim_table[i].oor;
         send_request(rq, stim_table[i].chk, want);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         drain();
         write_width(phase_width[p]);
         idle_on = (p != N_PHASES - 1);
         quiet = 1'b0;
         for (int k = 0; k < PHASE_REQUESTS; k++) begin
            if (k % 25 == 0) quiet = ($urandom_range(0, 2) == 0);
            if (idle_on && !quiet && $urandom_range(0, 3) == 0) idle_burst();
            // hold off until the block has answered everything
            if (idle_on && k == 40 && (p == 0 || $urandom_range(0, 1) == 0)) drain();
            send_request(random_request(), 1'b0, '0);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
design/bpfs_pkg.sv
design/bpfs_ctrl.sv
design/bpfs_dp.sv
design/bit_packed_field_store.sv
dv/tb.sv
